>>> hw/rtl/fpf_pkg.sv
// Shared constants, types and helper functions for the file name pattern filter.
package fpf_pkg;

  localparam int unsigned WIN_CHARS = 24;
  localparam int unsigned WIN_BITS  = WIN_CHARS * 8;
  localparam int unsigned PAT_COUNT = 11;
  localparam int unsigned SUF_COUNT = 4;
  localparam int unsigned SUF_LEN   = 4;

  typedef logic [7:0]          char_t;
  typedef logic [WIN_BITS-1:0] win_t;

  typedef struct packed {
    logic sens;
    logic hid;
    logic suffix;
  } hits_t;

  localparam char_t CHAR_SLASH = 8'h2f;
  localparam char_t CHAR_COLON = 8'h3a;
  localparam char_t CHAR_DOT   = 8'h2e;
  localparam char_t CHAR_UC_A  = 8'h41;
  localparam char_t CHAR_UC_Z  = 8'h5a;
  localparam char_t CASE_STEP  = 8'h20;

  // Patterns are stored with their last byte in the low byte, to line up
  // with the newest byte of the window.
  localparam win_t PAT_TEXT [PAT_COUNT] = '{
    WIN_BITS'({8'h6f, 8'h70, 8'h65, 8'h6e, 8'h61, 8'h69, 8'h6b, 8'h65, 8'h79}),
    WIN_BITS'({8'h6f, 8'h70, 8'h65, 8'h6e, 8'h61, 8'h69, 8'h5f, 8'h61, 8'h70,
               8'h69, 8'h5f, 8'h6b, 8'h65, 8'h79}),
    WIN_BITS'({8'h6f, 8'h76, 8'h6d, 8'h73, 8'h5f, 8'h61, 8'h67, 8'h65, 8'h6e,
               8'h74, 8'h5f, 8'h68, 8'h65, 8'h61, 8'h64, 8'h65, 8'h72, 8'h73}),
    WIN_BITS'({8'h6f, 8'h70, 8'h65, 8'h6e, 8'h61, 8'h69, 8'h5f, 8'h74, 8'h65,
               8'h73, 8'h74, 8'h5f, 8'h68, 8'h65, 8'h61, 8'h64, 8'h65, 8'h72,
               8'h73}),
    WIN_BITS'({8'h2e, 8'h70, 8'h65, 8'h6d}),
    WIN_BITS'({8'h2e, 8'h6b, 8'h65, 8'h79}),
    WIN_BITS'({8'h6f, 8'h76, 8'h6d, 8'h73, 8'h5f, 8'h61, 8'h67, 8'h65, 8'h6e,
               8'h74, 8'h5f, 8'h72, 8'h65, 8'h71, 8'h75, 8'h65, 8'h73, 8'h74,
               8'h2e, 8'h6a, 8'h73, 8'h6f, 8'h6e}),
    WIN_BITS'({8'h6f, 8'h76, 8'h6d, 8'h73, 8'h5f, 8'h61, 8'h67, 8'h65, 8'h6e,
               8'h74, 8'h5f, 8'h72, 8'h65, 8'h73, 8'h70, 8'h6f, 8'h6e, 8'h73,
               8'h65, 8'h2e, 8'h6a, 8'h73, 8'h6f, 8'h6e}),
    WIN_BITS'({8'h6f, 8'h70, 8'h65, 8'h6e, 8'h61, 8'h69, 8'h5f, 8'h6d, 8'h6f,
               8'h64, 8'h65, 8'h6c, 8'h73, 8'h2e, 8'h6a, 8'h73, 8'h6f, 8'h6e}),
    WIN_BITS'({8'h5f, 8'h62, 8'h61, 8'h63, 8'h6b, 8'h75, 8'h70}),
    WIN_BITS'({8'h5f, 8'h62, 8'h65, 8'h66, 8'h6f, 8'h72, 8'h65, 8'h5f})
  };

  localparam int unsigned PAT_LEN [PAT_COUNT] = '{
    9, 14, 18, 19, 4, 4, 23, 24, 18, 7, 8
  };

  // Bit i marks pattern i as a member of the set.
  localparam logic [PAT_COUNT-1:0] PAT_SENS = 11'b000_0011_1111;
  localparam logic [PAT_COUNT-1:0] PAT_HID  = 11'b111_1100_0101;

  localparam logic [SUF_LEN*8-1:0] SUF_TEXT [SUF_COUNT] = '{
    {8'h2e, 8'h6f, 8'h62, 8'h6a},
    {8'h2e, 8'h65, 8'h78, 8'h65},
    {8'h2e, 8'h62, 8'h61, 8'h6b},
    {8'h2e, 8'h6f, 8'h6c, 8'h64}
  };

  function automatic char_t fold_char(input char_t c);
    char_t r;
    r = c;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      r = c + CASE_STEP;
    end
    return r;
  endfunction

  function automatic win_t len_mask(input int unsigned len);
    win_t m;
    m = '0;
    for (int unsigned k = 0; k < WIN_CHARS; k++) begin
      if (k < len) begin
        m[k*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/filename_pattern_filter_top.sv
// Streaming file name filter: safe, sensitive and hidden flags per name.
// Latency: the result of a name is valid the cycle after its last transaction is accepted.
// Throughput: one character per cycle while in_stall_o is low; all pattern compares run in parallel, combinationally.
// The single result register stalls input only while a result waits and out_stall_i is high.
// Reset (rst_ni low, asynchronous) clears the window, all sticky flags and the result valid.
module filename_pattern_filter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       no_char_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       path_safe_o,
  output logic       path_sensitive_o,
  output logic       entry_hidden_o
);

  fpf_pkg::win_t  win_q, win_d;
  fpf_pkg::hits_t hits;
  fpf_pkg::char_t c_fold;

  logic nonempty_q, nonempty_d;
  logic unsafe_q, unsafe_d;
  logic sens_q, sens_d;
  logic hid_q, hid_d;
  logic dot_q, dot_d;
  logic out_valid_q;
  logic safe_q, out_sens_q, out_hid_q;
  logic in_acc, take;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign take       = in_acc & ~no_char_i;
  assign c_fold     = fpf_pkg::fold_char(char_code_i);

  fpf_match u_match (
    .win_i  (win_d),
    .hits_o (hits)
  );

  always_comb begin
    win_d      = win_q;
    nonempty_d = nonempty_q;
    unsafe_d   = unsafe_q;
    dot_d      = dot_q;
    if (take) begin
      win_d      = {win_q[fpf_pkg::WIN_BITS-9:0], c_fold};
      nonempty_d = 1'b1;
      dot_d      = c_fold == fpf_pkg::CHAR_DOT;
      if ((~nonempty_q && c_fold == fpf_pkg::CHAR_SLASH) ||
          c_fold == fpf_pkg::CHAR_COLON ||
          (dot_q && c_fold == fpf_pkg::CHAR_DOT)) begin
        unsafe_d = 1'b1;
      end
    end
    sens_d = sens_q | (take & hits.sens);
    hid_d  = hid_q | (take & hits.hid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      nonempty_q <= 1'b0;
      unsafe_q   <= 1'b0;
      sens_q     <= 1'b0;
      hid_q      <= 1'b0;
      dot_q      <= 1'b0;
    end else if (in_acc && last_char_i) begin
      // Name complete: clear for the next one
      win_q      <= '0;
      nonempty_q <= 1'b0;
      unsafe_q   <= 1'b0;
      sens_q     <= 1'b0;
      hid_q      <= 1'b0;
      dot_q      <= 1'b0;
    end else if (in_acc) begin
      win_q      <= win_d;
      nonempty_q <= nonempty_d;
      unsafe_q   <= unsafe_d;
      sens_q     <= sens_d;
      hid_q      <= hid_d;
      dot_q      <= dot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && last_char_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; an empty name leaves all flags low
  always_ff @(posedge clk_i) begin
    if (in_acc && last_char_i) begin
      safe_q     <= nonempty_d & ~unsafe_d;
      out_sens_q <= nonempty_d & sens_d;
      out_hid_q  <= nonempty_d & (hid_d | hits.suffix);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign path_safe_o      = safe_q;
  assign path_sensitive_o = out_sens_q;
  assign entry_hidden_o   = out_hid_q;

endmodule

>>> hw/rtl/fpf_match.sv
// Parallel compare of the folded window against all fixed patterns and suffixes.
module fpf_match (
  input  fpf_pkg::win_t  win_i,
  output fpf_pkg::hits_t hits_o
);

  logic [fpf_pkg::PAT_COUNT-1:0] pat_hit;
  logic [fpf_pkg::SUF_COUNT-1:0] suf_hit;

  // Patterns hold no zero bytes, so a cleared window slot never completes a hit.
  always_comb begin
    for (int unsigned i = 0; i < fpf_pkg::PAT_COUNT; i++) begin
      pat_hit[i] = ((win_i ^ fpf_pkg::PAT_TEXT[i]) &
                    fpf_pkg::len_mask(fpf_pkg::PAT_LEN[i])) == '0;
    end
    for (int unsigned s = 0; s < fpf_pkg::SUF_COUNT; s++) begin
      suf_hit[s] = win_i[fpf_pkg::SUF_LEN*8-1:0] == fpf_pkg::SUF_TEXT[s];
    end
  end

  assign hits_o.sens   = |(pat_hit & fpf_pkg::PAT_SENS);
  assign hits_o.hid    = |(pat_hit & fpf_pkg::PAT_HID);
  assign hits_o.suffix = |suf_hit;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the file name pattern filter: streams names and checks their flags.
module tb;
  typedef fpf_pkg::char_t char_t;

  localparam int WIN        = 24;
  localparam int WIN_W      = WIN * 8;
  localparam int NUM_PATS   = 11;
  localparam int NUM_SUFS   = 4;
  localparam int RAND_ITEMS = 1700;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_WAIT = 8;

  typedef logic [WIN_W-1:0] text_t;
  typedef struct packed {
    logic safe;
    logic sens;
    logic hid;
  } flags_t;
  typedef struct packed {
    char_t  code;
    logic   nc;
    logic   lst;
    logic   pinned;
    flags_t want;
  } row_t;

  localparam char_t CH_SLASH = "/";
  localparam char_t CH_COLON = ":";
  localparam char_t CH_DOT   = ".";
  localparam char_t CH_UNDER = "_";
  localparam char_t CH_LC_A  = "a";
  localparam char_t CH_LC_Z  = "z";
  localparam char_t CH_UC_A  = "A";
  localparam char_t CH_UC_Z  = "Z";
  localparam char_t CASE_BIT = 8'h20;

  // Leading bytes shared by the longer patterns, kept as codes.
  localparam logic [47:0] LEAD_SIX  = 48'h6f70_656e_6169;
  localparam logic [31:0] LEAD_FOUR = 32'h6f76_6d73;

  // Newest byte of a pattern sits in the low byte, as in the window.
  localparam text_t PAT_BYTES [NUM_PATS] = '{
    WIN_W'({LEAD_SIX, "key"}),
    WIN_W'({LEAD_SIX, "_api_key"}),
    WIN_W'({LEAD_FOUR, "_agent_headers"}),
    WIN_W'({LEAD_SIX, "_test_headers"}),
    WIN_W'(".pem"),
    WIN_W'(".key"),
    WIN_W'({LEAD_FOUR, "_agent_request.json"}),
    WIN_W'({LEAD_FOUR, "_agent_response.json"}),
    WIN_W'({LEAD_SIX, "_models.json"}),
    WIN_W'("_backup"),
    WIN_W'("_before_")
  };
  localparam int PAT_LEN [NUM_PATS] = '{9, 14, 18, 19, 4, 4, 23, 24, 18, 7, 8};
  localparam logic [NUM_PATS-1:0] IN_SENS = 11'b000_0011_1111;
  localparam logic [NUM_PATS-1:0] IN_HID  = 11'b111_1100_0101;
  localparam logic [31:0] SUF_BYTES [NUM_SUFS] = '{".obj", ".exe", ".bak", ".old"};

  localparam int NUM_ROWS = 22;
  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    '{8'h00,    1'b1, 1'b1, 1'b1, 3'b000},  // empty name
    '{8'hff,    1'b1, 1'b0, 1'b0, 3'b000},  // byte-less, not last: dropped
    '{"A",      1'b0, 1'b1, 1'b1, 3'b100},
    '{CH_SLASH, 1'b0, 1'b1, 1'b1, 3'b000},  // leading slash
    '{"x",      1'b0, 1'b0, 1'b0, 3'b000},
    '{CH_COLON, 1'b0, 1'b1, 1'b1, 3'b000},
    '{CH_DOT,   1'b0, 1'b0, 1'b0, 3'b000},
    '{CH_DOT,   1'b0, 1'b1, 1'b1, 3'b000},  // double dot
    '{8'h00,    1'b0, 1'b1, 1'b1, 3'b100},  // zero byte is an ordinary byte
    '{8'hff,    1'b0, 1'b1, 1'b1, 3'b100},
    '{CH_DOT,   1'b0, 1'b0, 1'b0, 3'b000},
    '{"P",      1'b0, 1'b0, 1'b0, 3'b000},
    '{"E",      1'b0, 1'b0, 1'b0, 3'b000},
    '{"M",      1'b0, 1'b1, 1'b1, 3'b110},
    '{CH_DOT,   1'b0, 1'b0, 1'b0, 3'b000},
    '{"O",      1'b0, 1'b0, 1'b0, 3'b000},
    '{"b",      1'b0, 1'b0, 1'b0, 3'b000},
    '{"j",      1'b0, 1'b0, 1'b0, 3'b000},
    '{8'h5a,    1'b1, 1'b1, 1'b1, 3'b101},  // byte-less end after bytes
    '{"Z",      1'b0, 1'b0, 1'b0, 3'b000},
    '{"@",      1'b0, 1'b0, 1'b0, 3'b000},
    '{"[",      1'b0, 1'b1, 1'b1, 3'b100}
  };

  logic  clk_i;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_stall_o;
  char_t char_code_i = '0;
  logic  no_char_i   = 1'b0;
  logic  last_char_i = 1'b0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  logic  path_safe_o;
  logic  path_sensitive_o;
  logic  entry_hidden_o;

  filename_pattern_filter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_code_i      (char_code_i),
    .no_char_i        (no_char_i),
    .last_char_i      (last_char_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .path_safe_o      (path_safe_o),
    .path_sensitive_o (path_sensitive_o),
    .entry_hidden_o   (entry_hidden_o)
  );

  // Name state as the block should hold it.
  text_t seen_win;
  int    seen_cnt;
  logic  bad_seen;
  logic  sens_seen;
  logic  hid_seen;
  logic  dot_before;

  flags_t pending_flags [$];
  char_t  name_q [$];
  int     fail_cnt     = 0;
  int     rand_items   = 0;
  int     names_done   = 0;
  int     results_seen = 0;
  bit     burst_in     = 1'b0;
  bit     burst_out    = 1'b0;
  bit     hold_req     = 1'b0;

  function automatic logic tail_is(text_t pat, int len);
    text_t m;
    m = (text_t'(1) << (8 * len)) - text_t'(1);
    return (len <= seen_cnt) && ((seen_win & m) == pat);
  endfunction

  function automatic void clear_name();
    seen_win   = '0;
    seen_cnt   = 0;
    bad_seen   = 1'b0;
    sens_seen  = 1'b0;
    hid_seen   = 1'b0;
    dot_before = 1'b0;
  endfunction

  function automatic void take_char(char_t raw);
    char_t c;
    c = raw;
    if (raw >= CH_UC_A && raw <= CH_UC_Z) begin
      c = raw | CASE_BIT;
    end
    if ((seen_cnt == 0 && c == CH_SLASH) || c == CH_COLON || (c == CH_DOT && dot_before)) begin
      bad_seen = 1'b1;
    end
    dot_before = (c == CH_DOT);
    seen_win = {seen_win[WIN_W-9:0], c};
    if (seen_cnt < WIN) begin
      seen_cnt++;
    end
    for (int p = 0; p < NUM_PATS; p++) begin
      if (tail_is(PAT_BYTES[p], PAT_LEN[p])) begin
        sens_seen |= IN_SENS[p];
        hid_seen  |= IN_HID[p];
      end
    end
  endfunction

  function automatic flags_t close_name();
    flags_t f;
    f = '0;
    if (seen_cnt != 0) begin
      f.safe = !bad_seen;
      f.sens = sens_seen;
      f.hid  = hid_seen;
      for (int s = 0; s < NUM_SUFS; s++) begin
        if (tail_is(text_t'(SUF_BYTES[s]), 4)) begin
          f.hid = 1'b1;
        end
      end
    end
    clear_name();
    return f;
  endfunction

  function automatic char_t pat_char(int p, int k);
    return PAT_BYTES[p][8*(PAT_LEN[p]-1-k) +: 8];
  endfunction

  function automatic char_t mixed_case(char_t c);
    if (c >= CH_LC_A && c <= CH_LC_Z && $urandom_range(0, 1) == 1) begin
      return c & ~CASE_BIT;
    end
    return c;
  endfunction

  function automatic char_t pick_char();
    int p;
    case ($urandom_range(0, 7))
      0, 1: return char_t'($urandom_range(0, 255));
      2, 3: begin
        p = $urandom_range(0, NUM_PATS - 1);
        return mixed_case(pat_char(p, $urandom_range(0, PAT_LEN[p] - 1)));
      end
      4: return ($urandom_range(0, 1) == 1) ? CH_DOT : CH_UNDER;
      default: return mixed_case(char_t'($urandom_range(CH_LC_A, CH_LC_Z)));
    endcase
  endfunction

  // Offer one transaction after a random gap, hold it until taken, then predict.
  task automatic send_char(char_t code, logic nc, logic lst, logic pinned, flags_t want);
    int     gap;
    flags_t f;
    gap = burst_in ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    no_char_i   <= nc;
    last_char_i <= lst;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (!nc) begin
      take_char(code);
    end
    if (lst) begin
      f = close_name();
      pending_flags.push_back(pinned ? want : f);
    end
  endtask

  task automatic compose_name();
    int p;
    int s;
    int cut;
    int pos;
    name_q.delete();
    if ($urandom_range(0, 11) == 0) begin
      return;
    end
    if ($urandom_range(0, 7) == 0) begin
      name_q.push_back(CH_SLASH);
    end
    repeat ($urandom_range(1, 4)) begin
      p = $urandom_range(0, NUM_PATS - 1);
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 6)) name_q.push_back(pick_char());
        3: repeat ($urandom_range(20, 30)) name_q.push_back(pick_char());
        4, 5: begin
          for (int k = 0; k < PAT_LEN[p]; k++) name_q.push_back(mixed_case(pat_char(p, k)));
        end
        6: begin
          cut = $urandom_range(1, PAT_LEN[p] - 1);
          for (int k = 0; k < cut; k++) name_q.push_back(mixed_case(pat_char(p, k)));
        end
        7: begin
          s = $urandom_range(0, NUM_SUFS - 1);
          for (int k = 0; k < 4; k++) name_q.push_back(mixed_case(SUF_BYTES[s][8*(3-k) +: 8]));
        end
        8: begin
          case ($urandom_range(0, 2))
            0: name_q.push_back(CH_COLON);
            1: begin
              name_q.push_back(CH_DOT);
              name_q.push_back(CH_DOT);
            end
            default: name_q.push_back(CH_SLASH);
          endcase
        end
        default: begin
          // near miss: one byte of the pattern swapped out
          pos = $urandom_range(0, PAT_LEN[p] - 1);
          for (int k = 0; k < PAT_LEN[p]; k++) begin
            name_q.push_back((k == pos) ? pick_char() : mixed_case(pat_char(p, k)));
          end
        end
      endcase
    end
    if ($urandom_range(0, 2) == 0) begin
      s = $urandom_range(0, NUM_SUFS - 1);
      for (int k = 0; k < 4; k++) name_q.push_back(mixed_case(SUF_BYTES[s][8*(3-k) +: 8]));
    end
  endtask

  task automatic send_name();
    bit close_empty;
    close_empty = (name_q.size() == 0) || ($urandom_range(0, 4) == 0);
    burst_in    = ($urandom_range(0, 3) == 0);
    foreach (name_q[i]) begin
      if ($urandom_range(0, 9) == 0) begin
        send_char(char_t'($urandom), 1'b1, 1'b0, 1'b0, '0);
        rand_items++;
      end
      send_char(name_q[i], 1'b0, !close_empty && (i == name_q.size() - 1), 1'b0, '0);
      rand_items++;
    end
    if (close_empty) begin
      send_char(char_t'($urandom), 1'b1, 1'b1, 1'b0, '0);
      rand_items++;
    end
    names_done++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall before each transaction, one long hold-off on request.
  initial begin
    int     n;
    flags_t want;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          burst_out = !burst_out;
        end
        n = burst_out ? 0 : $urandom_range(0, 7);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
      results_seen++;
      if (pending_flags.size() == 0) begin
        $error("result with no name pending: safe %0b sensitive %0b hidden %0b",
               path_safe_o, path_sensitive_o, entry_hidden_o);
        fail_cnt++;
      end else begin
        want = pending_flags.pop_front();
        if (path_safe_o !== want.safe) begin
          $error("path_safe: expected %0b, got %0b", want.safe, path_safe_o);
          fail_cnt++;
        end
        if (path_sensitive_o !== want.sens) begin
          $error("path_sensitive: expected %0b, got %0b", want.sens, path_sensitive_o);
          fail_cnt++;
        end
        if (entry_hidden_o !== want.hid) begin
          $error("entry_hidden: expected %0b, got %0b", want.hid, entry_hidden_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    clear_name();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[r]) begin
      send_char(DIR_ROWS[r].code, DIR_ROWS[r].nc, DIR_ROWS[r].lst, DIR_ROWS[r].pinned,
                DIR_ROWS[r].want);
    end

    while (rand_items < RAND_ITEMS) begin
      if (!held && rand_items >= 600) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && rand_items >= 1200) begin
        // drain every pending result before offering more
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_flags.size() != 0);
      end
      compose_name();
      send_name();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_flags.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Ran %0d directed transactions, then %0d random names in %0d transactions.",
             NUM_ROWS, names_done, rand_items);
    $display("Checked %0d results, with one long output hold-off and one full drain.",
             results_seen);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/fpf_pkg.sv
hw/rtl/fpf_match.sv
hw/rtl/filename_pattern_filter_top.sv
tb/tb.sv
